// ===== hw/rtl/trigram_password_checker_unit_macros.svh =====
// assertion macros for the trigram password checker
// expects i_clk and i_rst_n in the scope of each use
`ifndef TRIGRAM_PASSWORD_CHECKER_UNIT_MACROS_SVH
`define TRIGRAM_PASSWORD_CHECKER_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define TPC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tpc check failed");

// next-cycle implication, checked outside reset
`define TPC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tpc check failed");

`endif

// ===== hw/rtl/tpc_pkg.sv =====
// shared types, codes and helpers for the trigram password checker
// no dependencies
`default_nettype none

package tpc_pkg;

    localparam int unsigned ALPHA       = 27;
    localparam int unsigned TABLE_DEPTH = 729;
    localparam int unsigned ADDR_W      = 10;
    localparam int unsigned WORD_W      = 27;
    localparam int unsigned CODE_W      = 5;
    localparam int unsigned CFG_W       = 5;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned MISS_W      = 4;

    typedef logic [1:0]          t_action;
    typedef logic [1:0]          t_verdict;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [CODE_W-1:0]   t_code;
    typedef logic [ADDR_W-1:0]   t_addr;
    typedef logic [WORD_W-1:0]   t_word;
    typedef logic [MISS_W-1:0]   t_miss;

    localparam t_action ACT_LOAD = 2'd0;
    localparam t_action ACT_CHAR = 2'd1;
    localparam t_action ACT_END  = 2'd2;

    localparam t_verdict VERDICT_OK      = 2'd0;
    localparam t_verdict VERDICT_SHORT   = 2'd1;
    localparam t_verdict VERDICT_LONG    = 2'd2;
    localparam t_verdict VERDICT_OBVIOUS = 2'd3;

    localparam t_cfg_idx CFG_MIN_LENGTH  = 2'd0;
    localparam t_cfg_idx CFG_MAX_LENGTH  = 2'd1;
    localparam t_cfg_idx CFG_MIN_UNUSUAL = 2'd2;

    localparam logic [CFG_W-1:0]  RST_MIN_LENGTH  = 5'd5;
    localparam logic [CFG_W-1:0]  RST_MAX_LENGTH  = 5'd8;
    localparam logic [MISS_W-1:0] RST_MIN_UNUSUAL = 4'd2;
    localparam t_miss             MISS_MAX        = 4'd15;
    localparam t_addr             LAST_INDEX      = 10'd728;

    localparam logic [7:0] LOWER_A = 8'h61;
    localparam logic [7:0] LOWER_Z = 8'h7a;
    localparam logic [7:0] UPPER_A = 8'h41;
    localparam logic [7:0] UPPER_Z = 8'h5a;

    // letters of either case give 1..26, anything else 0
    function automatic t_code map_byte(input logic [7:0] b);
        logic [7:0] diff;
        begin
            diff = 8'd0;
            if (b >= LOWER_A && b <= LOWER_Z) begin
                diff = b - (LOWER_A - 8'd1);
            end else if (b >= UPPER_A && b <= UPPER_Z) begin
                diff = b - (UPPER_A - 8'd1);
            end
            return diff[CODE_W-1:0];
        end
    endfunction

    function automatic t_addr pair_addr(input t_code older, input t_code newer);
        return t_addr'(older) * t_addr'(ALPHA) + t_addr'(newer);
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tpc_req_if.sv =====
// request channel of the trigram password checker
// depends on tpc_pkg
`default_nettype none

interface tpc_req_if;
    import tpc_pkg::*;

    logic           valid;
    logic           ready;
    t_action        action;
    logic [7:0]     char_byte;
    t_addr          table_index;
    t_word          table_word;

    modport source (output valid, output action, output char_byte,
                    output table_index, output table_word, input ready);
    modport sink   (input valid, input action, input char_byte,
                    input table_index, input table_word, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tpc_rsp_if.sv =====
// result channel of the trigram password checker
// depends on tpc_pkg
`default_nettype none

interface tpc_rsp_if #(
    parameter int unsigned LEN_W = 5
);
    import tpc_pkg::*;

    logic             valid;
    logic             ready;
    t_verdict         verdict;
    logic [LEN_W-1:0] word_length;
    t_miss            unusual_count;

    modport source (output valid, output verdict, output word_length,
                    output unusual_count, input ready);
    modport sink   (input valid, input verdict, input word_length,
                    input unusual_count, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/trigram_password_checker_unit.sv =====
// top level of the trigram password checker
// depends on tpc_pkg, tpc_req_if, tpc_rsp_if, tpc_ram and the macros header
`default_nettype none

// Takes one request per cycle unless a waiting result is stalled: table loads,
// password characters and end-of-word marks are all accepted alike. The 729-word
// trigram table sits in a RAM with registered read; its read address is formed
// every cycle from the next two stored codes, so the word for the coming
// character is already waiting when that character arrives. A table write to
// the address being read ahead is forwarded. End of word puts the verdict in
// an output register in the cycle after the request; the block keeps taking
// requests while that result waits unless the result itself is stalled.
// Table entries read before being written return undefined data.
module trigram_password_checker_unit #(
    parameter int unsigned LEN_LIMIT = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire tpc_pkg::t_cfg_idx        i_cfg_idx,
    input  wire logic [tpc_pkg::CFG_W-1:0] i_cfg_data,
    tpc_req_if.sink                       i_req,
    tpc_rsp_if.source                     o_rsp
);
    import tpc_pkg::*;

`include "trigram_password_checker_unit_macros.svh"

    localparam int unsigned LEN_W = $clog2(LEN_LIMIT + 2);
    localparam int unsigned CMP_W = (LEN_W > CFG_W) ? LEN_W : CFG_W;
    localparam logic [LEN_W-1:0] LEN_SAT = LEN_W'(LEN_LIMIT + 1);

    // configuration
    logic [CFG_W-1:0]  r_min_length;
    logic [CFG_W-1:0]  r_max_length;
    t_miss             r_min_unusual;

    // word state
    t_code             r_older, n_older;
    t_code             r_newer, n_newer;
    logic [LEN_W-1:0]  r_count, n_count;
    t_miss             r_miss,  n_miss;

    // output register
    logic              r_ov, n_ov;
    t_verdict          r_verdict, n_verdict;
    logic [LEN_W-1:0]  r_len, n_len;
    t_miss             r_unusual, n_unusual;

    // table and forwarding
    logic              ram_we;
    t_addr             ram_raddr;
    t_word             ram_rdata;
    logic              r_fwd, n_fwd;
    t_word             r_fwd_word;
    t_word             entry;

    logic              req_acc;
    t_code             code;

    // no request is taken while reset is held
    assign i_req.ready = i_rst_n && (!r_ov || o_rsp.ready);
    assign req_acc     = i_req.valid && i_req.ready;
    assign code        = map_byte(i_req.char_byte);
    assign entry       = r_fwd ? r_fwd_word : ram_rdata;

    assign ram_we    = req_acc && (i_req.action == ACT_LOAD) && (i_req.table_index <= LAST_INDEX);
    assign ram_raddr = pair_addr(n_older, n_newer);
    assign n_fwd     = ram_we && (i_req.table_index == ram_raddr);

    tpc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_req.table_index),
        .i_wdata (i_req.table_word),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_older   = r_older;
        n_newer   = r_newer;
        n_count   = r_count;
        n_miss    = r_miss;
        n_ov      = r_ov && !o_rsp.ready;
        n_verdict = r_verdict;
        n_len     = r_len;
        n_unusual = r_unusual;
        if (req_acc) begin
            case (i_req.action)
                ACT_CHAR: begin
                    if (r_count >= LEN_W'(2) && !entry[code] && r_miss < MISS_MAX) begin
                        n_miss = r_miss + t_miss'(1);
                    end
                    n_older = r_newer;
                    n_newer = code;
                    if (r_count < LEN_SAT) begin
                        n_count = r_count + LEN_W'(1);
                    end
                end
                ACT_END: begin
                    // length checks come before the unusual count
                    if (CMP_W'(r_count) < CMP_W'(r_min_length)) begin
                        n_verdict = VERDICT_SHORT;
                    end else if (CMP_W'(r_count) > CMP_W'(r_max_length)) begin
                        n_verdict = VERDICT_LONG;
                    end else if (r_miss < r_min_unusual) begin
                        n_verdict = VERDICT_OBVIOUS;
                    end else begin
                        n_verdict = VERDICT_OK;
                    end
                    n_ov      = 1'b1;
                    n_len     = r_count;
                    n_unusual = r_miss;
                    n_older   = '0;
                    n_newer   = '0;
                    n_count   = '0;
                    n_miss    = '0;
                end
                default: begin
                    // table loads touch only the RAM, the unused code is dropped
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_length  <= RST_MIN_LENGTH;
            r_max_length  <= RST_MAX_LENGTH;
            r_min_unusual <= RST_MIN_UNUSUAL;
            r_older       <= '0;
            r_newer       <= '0;
            r_count       <= '0;
            r_miss        <= '0;
            r_ov          <= 1'b0;
            r_fwd         <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MIN_LENGTH:  r_min_length  <= i_cfg_data;
                    CFG_MAX_LENGTH:  r_max_length  <= i_cfg_data;
                    CFG_MIN_UNUSUAL: r_min_unusual <= i_cfg_data[MISS_W-1:0];
                    default: begin
                    end
                endcase
            end
            r_older <= n_older;
            r_newer <= n_newer;
            r_count <= n_count;
            r_miss  <= n_miss;
            r_ov    <= n_ov;
            r_fwd   <= n_fwd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_verdict  <= n_verdict;
        r_len      <= n_len;
        r_unusual  <= n_unusual;
        r_fwd_word <= i_req.table_word;
    end

    assign o_rsp.valid         = r_ov;
    assign o_rsp.verdict       = r_verdict;
    assign o_rsp.word_length   = r_len;
    assign o_rsp.unusual_count = r_unusual;

    // end of word always leaves a result and a clean word state
    `TPC_ASSERT_NEXT(a_end_result, req_acc && i_req.action == ACT_END,
                     r_ov && r_count == '0 && r_miss == '0)
    `TPC_ASSERT_NEXT(a_end_codes, req_acc && i_req.action == ACT_END,
                     r_older == '0 && r_newer == '0)
    // no triple is counted before the third character
    `TPC_ASSERT_NEXT(a_no_early_miss, req_acc && i_req.action == ACT_CHAR && r_count < LEN_W'(2),
                     r_miss == $past(r_miss))
    `TPC_ASSERT_IMPL(a_count_sat, 1'b1, r_count <= LEN_SAT)

endmodule

`default_nettype wire

// ===== hw/rtl/tpc_ram.sv =====
// generic single-write, single-read RAM with registered read data
// no dependencies
`default_nettype none

module tpc_ram #(
    parameter int unsigned WIDTH = 27,
    parameter int unsigned DEPTH = 729
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// testbench for trigram_password_checker_unit: directed and random requests with
// randomized handshakes, each verdict checked against a behavioral predictor
// depends on tpc_pkg, tpc_req_if, tpc_rsp_if and the checker RTL
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tpc_pkg::*;

    localparam int unsigned LEN_LIMIT   = 16;
    localparam int unsigned PHASE_ITEMS = 280;
    localparam int unsigned LONG_HOLD   = 300;
    localparam int unsigned DRAIN_WAIT  = 4;
    localparam int unsigned MAX_SHOWN   = 10;
    localparam t_action     ACT_NONE    = 2'd3;

    typedef struct packed {
        t_action    action;
        logic [7:0] char_byte;
        t_addr      table_index;
        t_word      table_word;
    } request_t;

    typedef struct packed {
        t_verdict   verdict;
        logic [4:0] word_length;
        t_miss      unusual_count;
    } word_report_t;

    logic              i_clk     = 1'b0;
    logic              i_rst_n   = 1'b0;
    logic              cfg_we    = 1'b0;
    t_cfg_idx          cfg_idx   = CFG_MIN_LENGTH;
    logic [CFG_W-1:0]  cfg_data  = '0;
    logic              tx_valid  = 1'b0;
    request_t          tx_req    = '0;
    logic              rx_ready  = 1'b0;
    logic              req_taken = 1'b0;

    // predictor state
    t_word        trigram_words [TABLE_DEPTH];
    t_code        pair_older      = '0;
    t_code        pair_newer      = '0;
    logic [4:0]   chars_seen      = '0;
    t_miss        misses_seen     = '0;
    logic [4:0]   min_len_reg     = RST_MIN_LENGTH;
    logic [4:0]   max_len_reg     = RST_MAX_LENGTH;
    t_miss        min_unusual_reg = RST_MIN_UNUSUAL;
    word_report_t expected_reports [$];

    // request planning state
    request_t     pending_requests [$];
    bit           entry_loaded [TABLE_DEPTH];
    t_code        plan_older    = '0;
    t_code        plan_newer    = '0;
    int unsigned  plan_len      = 0;
    int unsigned  planned_items = 0;

    int unsigned  tx_idle_pct = 11;
    int unsigned  rx_idle_pct = 66;
    bit           hold_armed  = 1'b0;
    int unsigned  hold_cycles = 0;

    int unsigned  accepted_requests = 0;
    int unsigned  checked_reports   = 0;
    int unsigned  fail_count        = 0;
    int unsigned  verdict_tally [4] = '{0, 0, 0, 0};
    int unsigned  length_sat        = 0;
    int unsigned  miss_sat          = 0;

    tpc_req_if req_ch ();
    tpc_rsp_if rsp_ch ();

    assign req_ch.valid       = tx_valid;
    assign req_ch.action      = tx_req.action;
    assign req_ch.char_byte   = tx_req.char_byte;
    assign req_ch.table_index = tx_req.table_index;
    assign req_ch.table_word  = tx_req.table_word;
    assign rsp_ch.ready       = rx_ready;

    trigram_password_checker_unit #(.LEN_LIMIT(LEN_LIMIT)) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_ch.sink),
        .o_rsp      (rsp_ch.source)
    );

    function automatic t_code letter_code(input logic [7:0] b);
        if (b >= LOWER_A && b <= LOWER_Z) begin
            return t_code'(b - LOWER_A + 8'd1);
        end
        if (b >= UPPER_A && b <= UPPER_Z) begin
            return t_code'(b - UPPER_A + 8'd1);
        end
        return '0;
    endfunction

    task automatic grade_request(input request_t r);
        word_report_t rep;
        t_code        code;
        t_word        entry;
        case (r.action)
            ACT_LOAD: begin
                // loads past the last entry are dropped
                if (r.table_index <= LAST_INDEX) begin
                    trigram_words[r.table_index] = r.table_word;
                end
            end
            ACT_CHAR: begin
                code = letter_code(r.char_byte);
                if (chars_seen >= 5'd2) begin
                    entry = trigram_words[pair_older * ALPHA + pair_newer];
                    if (entry[code] == 1'b0 && misses_seen != MISS_MAX) begin
                        misses_seen = misses_seen + 1'b1;
                    end
                end
                pair_older = pair_newer;
                pair_newer = code;
                if (chars_seen <= LEN_LIMIT) begin
                    chars_seen = chars_seen + 1'b1;
                end
            end
            ACT_END: begin
                // length checks win over the unusual count
                if (chars_seen < min_len_reg) begin
                    rep.verdict = VERDICT_SHORT;
                end else if (chars_seen > max_len_reg) begin
                    rep.verdict = VERDICT_LONG;
                end else if (misses_seen < min_unusual_reg) begin
                    rep.verdict = VERDICT_OBVIOUS;
                end else begin
                    rep.verdict = VERDICT_OK;
                end
                rep.word_length   = chars_seen;
                rep.unusual_count = misses_seen;
                expected_reports.push_back(rep);
                pair_older  = '0;
                pair_newer  = '0;
                chars_seen  = '0;
                misses_seen = '0;
            end
            default: begin
            end
        endcase
    endtask

    function automatic t_word pick_table_word();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            default: return t_word'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_non_letter();
        logic [7:0] b;
        b = 8'($urandom);
        while (letter_code(b) != '0) begin
            b = 8'($urandom);
        end
        return b;
    endfunction

    task automatic plan_request(input t_action a, input logic [7:0] b, input t_addr idx,
                                input t_word w);
        request_t r;
        r.action      = a;
        r.char_byte   = b;
        r.table_index = idx;
        r.table_word  = w;
        pending_requests.push_back(r);
        if (a == ACT_LOAD && idx <= LAST_INDEX) begin
            entry_loaded[idx] = 1'b1;
            planned_items++;
        end else if (a == ACT_CHAR || a == ACT_END) begin
            planned_items++;
        end
    endtask

    // a lookup of a never-loaded entry is avoided by loading it first
    task automatic plan_char(input logic [7:0] b);
        int unsigned pair;
        pair = plan_older * ALPHA + plan_newer;
        if (plan_len >= 2 && !entry_loaded[pair]) begin
            plan_request(ACT_LOAD, 8'($urandom), t_addr'(pair), pick_table_word());
        end
        plan_request(ACT_CHAR, b, t_addr'($urandom), t_word'($urandom));
        plan_older = plan_newer;
        plan_newer = letter_code(b);
        plan_len++;
    endtask

    task automatic plan_end();
        plan_request(ACT_END, 8'($urandom), t_addr'($urandom), t_word'($urandom));
        plan_older = '0;
        plan_newer = '0;
        plan_len   = 0;
    endtask

    task automatic plan_random_word();
        int unsigned kind;
        int unsigned n;
        logic [7:0]  b;
        kind = $urandom_range(0, 19);
        if (kind == 0) begin
            n = $urandom_range(17, 22);
        end else if (kind < 4) begin
            n = $urandom_range(0, 4);
        end else begin
            n = $urandom_range(3, 12);
        end
        for (int unsigned k = 0; k < n; k++) begin
            // long non-letter runs saturate the length counter
            if (kind == 0) begin
                b = pick_non_letter();
            end else if ($urandom_range(0, 6) == 0) begin
                b = 8'($urandom);
            end else begin
                b = ($urandom_range(0, 1) ? LOWER_A : UPPER_A) + 8'($urandom_range(0, 25));
            end
            plan_char(b);
            case ($urandom_range(0, 24))
                0: plan_request(ACT_LOAD, 8'($urandom), t_addr'($urandom), pick_table_word());
                1: plan_request(ACT_NONE, 8'($urandom), t_addr'($urandom), t_word'($urandom));
                default: begin
                end
            endcase
        end
        plan_end();
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = value;
        case (idx)
            CFG_MIN_LENGTH:  min_len_reg     = value;
            CFG_MAX_LENGTH:  max_len_reg     = value;
            CFG_MIN_UNUSUAL: min_unusual_reg = t_miss'(value);
            default: begin
            end
        endcase
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_limits(input logic [4:0] min_len, input logic [4:0] max_len,
                              input logic [4:0] min_unusual);
        write_reg(CFG_MIN_LENGTH, min_len);
        write_reg(CFG_MAX_LENGTH, max_len);
        write_reg(CFG_MIN_UNUSUAL, min_unusual);
        @(posedge i_clk);
    endtask

    task automatic wait_idle();
        while (pending_requests.size() != 0 || tx_valid || expected_reports.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic run_random_phase(input int unsigned tx_pct, input int unsigned rx_pct);
        tx_idle_pct   = tx_pct;
        rx_idle_pct   = rx_pct;
        planned_items = 0;
        while (planned_items < PHASE_ITEMS) begin
            plan_random_word();
        end
        wait_idle();
    endtask

    initial begin : clock_gen
        forever #6 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin : request_drive
        if (!i_rst_n) begin
            tx_valid <= 1'b0;
        end else if (!tx_valid || req_taken) begin
            if (pending_requests.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                tx_req   <= pending_requests.pop_front();
                tx_valid <= 1'b1;
            end else begin
                tx_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : request_accept
        if (i_rst_n && tx_valid && req_ch.ready) begin
            grade_request(tx_req);
            accepted_requests++;
            req_taken <= 1'b1;
        end else begin
            req_taken <= 1'b0;
        end
    end

    // long hold-off once armed, so the result register and then the request side stall
    always @(negedge i_clk) begin : result_ready
        if (!i_rst_n) begin
            rx_ready <= 1'b0;
        end else if (hold_armed && hold_cycles < LONG_HOLD) begin
            hold_cycles <= hold_cycles + 1;
            rx_ready    <= 1'b0;
        end else begin
            rx_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin : result_check
        word_report_t want;
        if (i_rst_n && rsp_ch.valid && rx_ready) begin
            if (expected_reports.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_SHOWN) begin
                    $display("unexpected result: verdict %0d length %0d unusual %0d",
                             rsp_ch.verdict, rsp_ch.word_length, rsp_ch.unusual_count);
                end
            end else begin
                want = expected_reports.pop_front();
                checked_reports++;
                verdict_tally[want.verdict]++;
                if (want.word_length == LEN_LIMIT + 1) begin
                    length_sat++;
                end
                if (want.unusual_count == MISS_MAX) begin
                    miss_sat++;
                end
                if (rsp_ch.verdict !== want.verdict || rsp_ch.word_length !== want.word_length
                        || rsp_ch.unusual_count !== want.unusual_count) begin
                    fail_count++;
                    if (fail_count <= MAX_SHOWN) begin
                        $display("result %0d: expected verdict %0d length %0d unusual %0d, got %0d %0d %0d",
                                 checked_reports, want.verdict, want.word_length,
                                 want.unusual_count, rsp_ch.verdict, rsp_ch.word_length,
                                 rsp_ch.unusual_count);
                    end
                end
            end
        end
    end

    initial begin : stimulus
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(posedge i_clk);

        // directed part under reset limits
        plan_request(ACT_LOAD, 8'h00, '0, '0);
        plan_request(ACT_LOAD, 8'hff, LAST_INDEX, '1);
        plan_request(ACT_LOAD, 8'h00, '1, '1);
        plan_request(ACT_LOAD, 8'hff, LAST_INDEX + 1'b1, '0);
        plan_request(ACT_NONE, 8'hff, '1, '1);
        plan_end();
        // every triple allowed: too obvious
        plan_char("z");
        plan_char("Z");
        plan_char("z");
        plan_char("Z");
        plan_char("z");
        plan_end();
        // non-letters around the letter ranges, all coded as zero
        plan_char(8'h00);
        plan_char(8'hff);
        plan_char(LOWER_A - 8'd1);
        plan_char(LOWER_Z + 8'd1);
        plan_char(UPPER_A - 8'd1);
        plan_char(UPPER_Z + 8'd1);
        plan_char(8'h00);
        plan_char(8'h00);
        plan_end();
        plan_char(UPPER_A);
        plan_char(LOWER_A);
        plan_char(UPPER_Z);
        plan_char(LOWER_Z);
        plan_end();
        wait_idle();

        set_limits(5'd0, 5'd16, 5'd0);
        run_random_phase(11, 66);
        set_limits(5'd16, 5'd0, 5'd15);
        run_random_phase(11, 66);
        set_limits(5'($urandom_range(0, 16)), 5'($urandom_range(0, 16)),
                   5'($urandom_range(0, 15)));
        run_random_phase(66, 11);
        set_limits(5'd3, 5'd12, 5'd1);
        run_random_phase(66, 11);
        set_limits(5'($urandom_range(0, 8)), 5'($urandom_range(8, 16)),
                   5'($urandom_range(0, 6)));
        hold_armed = 1'b1;
        run_random_phase(0, 0);
        set_limits(5'd4, 5'd16, 5'd15);
        run_random_phase(0, 0);

        $display("covered %0d requests, %0d verdicts: %0d acceptable, %0d short, %0d long, %0d obvious",
                 accepted_requests, checked_reports, verdict_tally[VERDICT_OK],
                 verdict_tally[VERDICT_SHORT], verdict_tally[VERDICT_LONG],
                 verdict_tally[VERDICT_OBVIOUS]);
        $display("length saturated in %0d words, unusual count in %0d, %0d failures",
                 length_sat, miss_sat, fail_count);
        if (fail_count == 0) begin
            $display("[trigram_password_checker_unit] OK");
        end else begin
            $display("[trigram_password_checker_unit] ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("timeout with %0d requests pending and %0d results outstanding",
                 pending_requests.size(), expected_reports.size());
        $display("[trigram_password_checker_unit] ERROR");
        $finish;
    end

endmodule
